// File: rtl/cartridge_bank_controller_core_assert.svh
// Assertion macros for the cartridge bank controller.
// Used by rtl/cartridge_bank_controller_core.sv and depends on nothing else.
`ifndef CARTRIDGE_BANK_CONTROLLER_CORE_ASSERT_SVH
`define CARTRIDGE_BANK_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CBC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/cbc_pkg.sv
// Types and constants for the cartridge bank controller.
// Has no dependencies; used by rtl/cartridge_bank_controller_core.sv.
`timescale 1ns / 1ps

package cbc_pkg;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_MBC1 = 2'd1,
        KIND_MBC2 = 2'd2,
        KIND_RSVD = 2'd3
    } t_ctrl_kind;

    typedef enum logic [1:0] {
        TGT_ROM      = 2'd0,
        TGT_EXT_RAM  = 2'd1,
        TGT_INTERNAL = 2'd2,
        TGT_NONE     = 2'd3
    } t_target;

    localparam int unsigned ADDR_W     = 16;
    localparam int unsigned DATA_W     = 8;
    localparam int unsigned MAP_W      = 21;
    localparam int unsigned ROM_BANK_W = 7;
    localparam int unsigned RAM_BANK_W = 2;

    localparam logic [3:0] ENABLE_CODE  = 4'hA;
    localparam logic [3:0] DISABLE_CODE = 4'h0;

    typedef struct packed {
        t_target            target;
        logic [MAP_W-1:0]   mapped_address;
        logic               write_strobe;
        logic               echo_mirror;
    } t_result;

    function automatic logic [ROM_BANK_W-1:0] fix_zero_bank(input logic [ROM_BANK_W-1:0] b);
        return (b == '0) ? ROM_BANK_W'(1) : b;
    endfunction

endpackage

// File: rtl/cartridge_bank_controller_core.sv
// Top level of the cartridge bank controller: bus decode, bank registers and output stage.
// Depends on rtl/cbc_pkg.sv and rtl/cartridge_bank_controller_core_assert.svh.
`timescale 1ns / 1ps

// The controller takes one bus transaction per clock cycle while o_in_stall is low and
// returns a registered result transaction for each. Decode and the bank register
// update are a single level of logic ahead of the output register, so a transaction
// can be accepted in every cycle with o_in_stall low. A skid register behind the output
// register lets one more transaction be accepted while a result is stalled; o_in_stall
// rises only when that skid register is also full. The controller kind is written through the
// configuration channel, which is always ready and should be used only while idle.

`include "cartridge_bank_controller_core_assert.svh"

module cartridge_bank_controller_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_action,
    input  logic [cbc_pkg::ADDR_W-1:0]  i_address,
    input  logic [cbc_pkg::DATA_W-1:0]  i_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [1:0]                  o_target,
    output logic [cbc_pkg::MAP_W-1:0]   o_mapped_address,
    output logic                        o_write_strobe,
    output logic                        o_echo_mirror
);
    import cbc_pkg::*;

    t_ctrl_kind              r_kind;
    logic [ROM_BANK_W-1:0]   r_rom_bank, n_rom_bank;
    logic [RAM_BANK_W-1:0]   r_ram_bank, n_ram_bank;
    logic                    r_ram_enable, n_ram_enable;
    logic                    r_rom_mode, n_rom_mode;
    t_result                 r_out, r_skid, n_result;
    logic                    r_out_valid, r_skid_valid;
    logic                    accept, out_free;
    logic                    is_mbc1, is_mbc2, reg_write;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign accept      = i_in_valid && !r_skid_valid;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign is_mbc1     = (r_kind == KIND_MBC1);
    assign is_mbc2     = (r_kind == KIND_MBC2);
    assign reg_write   = i_action && !i_address[15];

    always_comb begin
        n_rom_bank   = r_rom_bank;
        n_ram_bank   = r_ram_bank;
        n_ram_enable = r_ram_enable;
        n_rom_mode   = r_rom_mode;
        if (reg_write) begin
            unique case (i_address[14:13])
                2'd0: begin
                    if ((is_mbc1 || is_mbc2) && !(is_mbc2 && i_address[8])) begin
                        if (i_data[3:0] == ENABLE_CODE) begin
                            n_ram_enable = 1'b1;
                        end else if (i_data[3:0] == DISABLE_CODE) begin
                            n_ram_enable = 1'b0;
                        end
                    end
                end
                2'd1: begin
                    if (is_mbc2) begin
                        n_rom_bank = fix_zero_bank({3'b000, i_data[3:0]});
                    end else if (is_mbc1) begin
                        n_rom_bank = fix_zero_bank({r_rom_bank[6:5], i_data[4:0]});
                    end
                end
                2'd2: begin
                    if (is_mbc1) begin
                        if (r_rom_mode) begin
                            n_rom_bank = fix_zero_bank({i_data[1:0], r_rom_bank[4:0]});
                        end else begin
                            n_ram_bank = i_data[1:0];
                        end
                    end
                end
                default: begin
                    if (is_mbc1) begin
                        n_rom_mode = !i_data[0];
                        if (!i_data[0]) begin
                            n_ram_bank = '0;
                        end
                    end
                end
            endcase
        end
    end

    always_comb begin
        n_result.target         = TGT_INTERNAL;
        n_result.mapped_address = MAP_W'(i_address);
        n_result.write_strobe   = 1'b0;
        n_result.echo_mirror    = 1'b0;
        priority if (reg_write) begin
            n_result.target         = TGT_NONE;
            n_result.mapped_address = '0;
        end else if (i_address[15:14] == 2'b00) begin
            n_result.target = TGT_ROM;
        end else if (i_address[15:14] == 2'b01) begin
            n_result.target         = TGT_ROM;
            n_result.mapped_address = {r_rom_bank, i_address[13:0]};
        end else if (i_address[15:13] == 3'b101) begin
            n_result.target         = TGT_EXT_RAM;
            n_result.mapped_address = MAP_W'({r_ram_bank, i_address[12:0]});
            n_result.write_strobe   = i_action && r_ram_enable;
        end else if (i_action) begin
            n_result.write_strobe = 1'b1;
            n_result.echo_mirror  = (i_address[15:13] == 3'b111) && (i_address[12:9] != 4'hF);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind       <= KIND_NONE;
            r_rom_bank   <= ROM_BANK_W'(1);
            r_ram_bank   <= '0;
            r_ram_enable <= 1'b0;
            r_rom_mode   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_kind <= t_ctrl_kind'(i_cfg_data);
            end
            if (accept) begin
                r_rom_bank   <= n_rom_bank;
                r_ram_bank   <= n_ram_bank;
                r_ram_enable <= n_ram_enable;
                r_rom_mode   <= n_rom_mode;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= n_result;
            end
        end else if (accept) begin
            r_skid <= n_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_target         = r_out.target;
    assign o_mapped_address = r_out.mapped_address;
    assign o_write_strobe   = r_out.write_strobe;
    assign o_echo_mirror    = r_out.echo_mirror;

    `CBC_ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid full while output empty")
    `CBC_ASSERT_IMPL(a_rom_bank_nonzero, i_clk, i_rst_n, 1'b1, r_rom_bank != '0, "ROM bank register is zero")
    `CBC_ASSERT_IMPL(a_none_is_quiet, i_clk, i_rst_n, r_out_valid && (r_out.target == TGT_NONE), !r_out.write_strobe && !r_out.echo_mirror && (r_out.mapped_address == '0), "register write result drives a store")
    `CBC_ASSERT_IMPL(a_echo_internal, i_clk, i_rst_n, r_out_valid && r_out.echo_mirror, (r_out.target == TGT_INTERNAL) && r_out.write_strobe, "echo mirror outside internal write")
    `CBC_ASSERT_NEXT(a_stall_fills_skid, i_clk, i_rst_n, r_out_valid && i_out_stall && accept, r_skid_valid, "accepted transaction lost under stall")

endmodule
